FILE: rtl/ordered_array_list_engine_macros.svh
// Assertion macros used by the checker of the ordered array list engine.
`ifndef ORDERED_ARRAY_LIST_ENGINE_MACROS_SVH
`define ORDERED_ARRAY_LIST_ENGINE_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define OALE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Concurrent assertion that also holds while reset is high.
`define OALE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/oale_pkg.sv
// Types, constants and field layout shared by the ordered array list engine.
package oale_pkg;

  localparam int unsigned CAPACITY_DEF      = 256;
  localparam int unsigned ELEMENT_WIDTH_DEF = 32;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned IDX_A_W   = 9;
  localparam int unsigned IDX_B_W   = 8;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned LEN_W     = 9;

  localparam int unsigned OP_LSB    = 0;
  localparam int unsigned IA_LSB    = OP_LSB + OP_W;
  localparam int unsigned IB_LSB    = IA_LSB + IDX_A_W;
  localparam int unsigned VAL_LSB   = IB_LSB + IDX_B_W;
  localparam int unsigned S_USED_W  = VAL_LSB + VALUE_W;
  localparam int unsigned S_TDATA_W = ((S_USED_W + 7) / 8) * 8;

  localparam int unsigned RV_LSB    = STATUS_W;
  localparam int unsigned LEN_LSB   = RV_LSB + VALUE_W;
  localparam int unsigned M_USED_W  = LEN_LSB + LEN_W;
  localparam int unsigned M_TDATA_W = ((M_USED_W + 7) / 8) * 8;
  localparam int unsigned M_PAD_W   = M_TDATA_W - M_USED_W;

  typedef enum logic [OP_W-1:0] {
    OP_READ         = 3'd0,
    OP_INSERT       = 3'd1,
    OP_DELETE       = 3'd2,
    OP_DELETE_VALUE = 3'd3,
    OP_SWAP         = 3'd4,
    OP_CLEAR        = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PTR_HOLD  = 3'd0,
    PTR_COUNT = 3'd1,
    PTR_IA    = 3'd2,
    PTR_ZERO  = 3'd3,
    PTR_INC   = 3'd4,
    PTR_DEC   = 3'd5
  } ptr_op_t;

  typedef enum logic [2:0] {
    ADDR_PTR    = 3'd0,
    ADDR_PTR_M1 = 3'd1,
    ADDR_PTR_P1 = 3'd2,
    ADDR_IA     = 3'd3,
    ADDR_IB     = 3'd4
  } addr_sel_t;

  typedef enum logic [1:0] {
    WD_RDATA = 2'd0,
    WD_WORD  = 2'd1,
    WD_TMP   = 2'd2
  } wdata_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD  = 2'd0,
    CNT_INC   = 2'd1,
    CNT_DEC   = 2'd2,
    CNT_CLEAR = 2'd3
  } cnt_op_t;

  typedef struct packed {
    logic       load;
    ptr_op_t    ptr_op;
    logic       rd_en;
    addr_sel_t  rd_sel;
    logic       wr_en;
    addr_sel_t  wr_sel;
    wdata_sel_t wd_sel;
    logic       tmp_ld;
    cnt_op_t    cnt_op;
    logic       res_ld;
    status_t    res_status;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic ia_lt_cnt;
    logic ia_gt_cnt;
    logic ib_lt_cnt;
    logic ia_eq_ib;
    logic full;
    logic ptr_gt_ia;
    logic ptr_lt_cnt;
    logic ptr_p1_lt_cnt;
    logic match;
  } flags_t;

endpackage

FILE: rtl/oale_datapath.sv
// Datapath of the ordered array list engine: request registers, store, pointer, count, result.
module oale_datapath #(
  parameter int unsigned CAPACITY      = oale_pkg::CAPACITY_DEF,
  parameter int unsigned ELEMENT_WIDTH = oale_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [oale_pkg::S_TDATA_W-1:0] s_tdata,
  input  oale_pkg::cmd_t                 cmd,
  output oale_pkg::flags_t               flags,
  output logic [oale_pkg::M_TDATA_W-1:0] m_tdata
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > oale_pkg::IDX_A_W) ? CW : oale_pkg::IDX_A_W;
  localparam int unsigned EW = ELEMENT_WIDTH;
  localparam int unsigned VW = oale_pkg::VALUE_W;

  oale_pkg::op_t                  op;
  logic [oale_pkg::IDX_A_W-1:0]   ia;
  logic [oale_pkg::IDX_B_W-1:0]   ib;
  logic [EW-1:0]                  word;
  logic [CW-1:0]                  count;
  logic [CW-1:0]                  ptr;
  logic [EW-1:0]                  tmp;
  logic [EW-1:0]                  rdata;
  logic [EW-1:0]                  mem [CAPACITY];

  oale_pkg::status_t              res_status;
  logic [VW-1:0]                  res_value;
  logic [oale_pkg::LEN_W-1:0]     res_len;

  logic [VW-1:0]                  in_value;
  logic [EW-1:0]                  in_word;
  logic [VW-1:0]                  rd_ext;
  logic [CW-1:0]                  ptr_m1;
  logic [CW-1:0]                  ptr_p1;
  logic [AW-1:0]                  rd_addr;
  logic [AW-1:0]                  wr_addr;
  logic [EW-1:0]                  wdata;
  logic [XW-1:0]                  ia_x;
  logic [XW-1:0]                  cnt_x;
  logic [XW-1:0]                  ptr_x;

  assign in_value = s_tdata[oale_pkg::VAL_LSB +: VW];

  // A stored word is the low bits of the sign-extended request value.
  generate
    if (EW > VW) begin : g_wide
      assign in_word = {{(EW - VW){in_value[VW-1]}}, in_value};
      assign rd_ext  = rdata[VW-1:0];
    end else if (EW == VW) begin : g_equal
      assign in_word = in_value;
      assign rd_ext  = rdata;
    end else begin : g_narrow
      assign in_word = in_value[EW-1:0];
      assign rd_ext  = {{(VW - EW){rdata[EW-1]}}, rdata};
    end
  endgenerate

  assign ptr_m1 = ptr - CW'(1);
  assign ptr_p1 = ptr + CW'(1);

  function automatic logic [AW-1:0] addr_of(
    input oale_pkg::addr_sel_t          sel,
    input logic [CW-1:0]                p,
    input logic [CW-1:0]                pm1,
    input logic [CW-1:0]                pp1,
    input logic [oale_pkg::IDX_A_W-1:0] a,
    input logic [oale_pkg::IDX_B_W-1:0] b
  );
    logic [AW-1:0] r;
    unique case (sel)
      oale_pkg::ADDR_PTR:    r = AW'(p);
      oale_pkg::ADDR_PTR_M1: r = AW'(pm1);
      oale_pkg::ADDR_PTR_P1: r = AW'(pp1);
      oale_pkg::ADDR_IA:     r = AW'(a);
      oale_pkg::ADDR_IB:     r = AW'(b);
      default:               r = '0;
    endcase
    return r;
  endfunction

  assign rd_addr = addr_of(cmd.rd_sel, ptr, ptr_m1, ptr_p1, ia, ib);
  assign wr_addr = addr_of(cmd.wr_sel, ptr, ptr_m1, ptr_p1, ia, ib);

  always_comb begin
    unique case (cmd.wd_sel)
      oale_pkg::WD_RDATA: wdata = rdata;
      oale_pkg::WD_WORD:  wdata = word;
      oale_pkg::WD_TMP:   wdata = tmp;
      default:            wdata = rdata;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= oale_pkg::op_t'(s_tdata[oale_pkg::OP_LSB +: oale_pkg::OP_W]);
      ia   <= s_tdata[oale_pkg::IA_LSB +: oale_pkg::IDX_A_W];
      ib   <= s_tdata[oale_pkg::IB_LSB +: oale_pkg::IDX_B_W];
      word <= in_word;
    end
    if (cmd.tmp_ld) begin
      tmp <= rdata;
    end
  end

  // Single write port and single registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.ptr_op)
      oale_pkg::PTR_HOLD:  ptr <= ptr;
      oale_pkg::PTR_COUNT: ptr <= count;
      oale_pkg::PTR_IA:    ptr <= CW'(ia);
      oale_pkg::PTR_ZERO:  ptr <= '0;
      oale_pkg::PTR_INC:   ptr <= ptr_p1;
      oale_pkg::PTR_DEC:   ptr <= ptr_m1;
      default:             ptr <= ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (cmd.cnt_op)
        oale_pkg::CNT_HOLD:  count <= count;
        oale_pkg::CNT_INC:   count <= count + CW'(1);
        oale_pkg::CNT_DEC:   count <= count - CW'(1);
        oale_pkg::CNT_CLEAR: count <= '0;
        default:             count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      res_status <= cmd.res_status;
      res_value  <= (op == oale_pkg::OP_READ && cmd.res_status == oale_pkg::ST_OK) ?
                    rd_ext : '0;
      res_len    <= oale_pkg::LEN_W'(count);
    end
  end

  assign ia_x  = XW'(ia);
  assign cnt_x = XW'(count);
  assign ptr_x = XW'(ptr);

  always_comb begin
    flags.op            = op;
    flags.ia_lt_cnt     = ia_x < cnt_x;
    flags.ia_gt_cnt     = ia_x > cnt_x;
    flags.ib_lt_cnt     = XW'(ib) < cnt_x;
    flags.ia_eq_ib      = ia == oale_pkg::IDX_A_W'(ib);
    flags.full          = count >= CW'(CAPACITY);
    flags.ptr_gt_ia     = ptr_x > ia_x;
    flags.ptr_lt_cnt    = ptr < count;
    flags.ptr_p1_lt_cnt = ({1'b0, ptr} + {{CW{1'b0}}, 1'b1}) < {1'b0, count};
    flags.match         = rdata == word;
  end

  assign m_tdata = {{oale_pkg::M_PAD_W{1'b0}}, res_len, res_value, res_status};

endmodule

FILE: rtl/oale_ctrl.sv
// Controller of the ordered array list engine: request sequencing and the result handshake.
module oale_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  oale_pkg::flags_t flags,
  output oale_pkg::cmd_t   cmd
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'h001,
    S_DISPATCH = 12'h002,
    S_UP_RD    = 12'h004,
    S_UP_WR    = 12'h008,
    S_DN_RD    = 12'h010,
    S_DN_WR    = 12'h020,
    S_SCAN_RD  = 12'h040,
    S_SCAN_CMP = 12'h080,
    S_SW_RB    = 12'h100,
    S_SW_WA    = 12'h200,
    S_SW_WB    = 12'h400,
    S_FINISH   = 12'h800
  } state_t;

  state_t            state, state_next;
  oale_pkg::status_t st, st_next;
  logic              out_free;

  assign s_tready = state == S_IDLE;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    st_next    = st;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        st_next    = oale_pkg::ST_OK;
        state_next = S_FINISH;
        unique case (flags.op)
          oale_pkg::OP_READ: begin
            if (flags.ia_lt_cnt) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = oale_pkg::ADDR_IA;
            end else begin
              st_next = oale_pkg::ST_BAD_INDEX;
            end
          end
          oale_pkg::OP_INSERT: begin
            if (flags.ia_gt_cnt) begin
              st_next = oale_pkg::ST_BAD_INDEX;
            end else if (flags.full) begin
              st_next = oale_pkg::ST_FULL;
            end else begin
              cmd.ptr_op = oale_pkg::PTR_COUNT;
              state_next = S_UP_RD;
            end
          end
          oale_pkg::OP_DELETE: begin
            if (flags.ia_lt_cnt) begin
              cmd.ptr_op = oale_pkg::PTR_IA;
              state_next = S_DN_RD;
            end else begin
              st_next = oale_pkg::ST_BAD_INDEX;
            end
          end
          oale_pkg::OP_DELETE_VALUE: begin
            cmd.ptr_op = oale_pkg::PTR_ZERO;
            state_next = S_SCAN_RD;
          end
          oale_pkg::OP_SWAP: begin
            if (flags.ia_lt_cnt && flags.ib_lt_cnt && !flags.ia_eq_ib) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = oale_pkg::ADDR_IA;
              state_next = S_SW_RB;
            end else begin
              st_next = oale_pkg::ST_BAD_INDEX;
            end
          end
          oale_pkg::OP_CLEAR: begin
            cmd.cnt_op = oale_pkg::CNT_CLEAR;
          end
          default: begin
          end
        endcase
      end
      // Open a gap at index_a by moving entries up, from the top down.
      S_UP_RD: begin
        if (flags.ptr_gt_ia) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = oale_pkg::ADDR_PTR_M1;
          state_next = S_UP_WR;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = oale_pkg::ADDR_IA;
          cmd.wd_sel = oale_pkg::WD_WORD;
          cmd.cnt_op = oale_pkg::CNT_INC;
          state_next = S_FINISH;
        end
      end
      S_UP_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = oale_pkg::ADDR_PTR;
        cmd.wd_sel = oale_pkg::WD_RDATA;
        cmd.ptr_op = oale_pkg::PTR_DEC;
        state_next = S_UP_RD;
      end
      // Close the hole at the pointer by moving entries down.
      S_DN_RD: begin
        if (flags.ptr_p1_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = oale_pkg::ADDR_PTR_P1;
          state_next = S_DN_WR;
        end else begin
          cmd.cnt_op = oale_pkg::CNT_DEC;
          state_next = S_FINISH;
        end
      end
      S_DN_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = oale_pkg::ADDR_PTR;
        cmd.wd_sel = oale_pkg::WD_RDATA;
        cmd.ptr_op = oale_pkg::PTR_INC;
        state_next = S_DN_RD;
      end
      S_SCAN_RD: begin
        if (flags.ptr_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = oale_pkg::ADDR_PTR;
          state_next = S_SCAN_CMP;
        end else begin
          st_next    = oale_pkg::ST_NOT_FOUND;
          state_next = S_FINISH;
        end
      end
      S_SCAN_CMP: begin
        if (flags.match) begin
          state_next = S_DN_RD;
        end else begin
          cmd.ptr_op = oale_pkg::PTR_INC;
          state_next = S_SCAN_RD;
        end
      end
      S_SW_RB: begin
        cmd.tmp_ld = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = oale_pkg::ADDR_IB;
        state_next = S_SW_WA;
      end
      S_SW_WA: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = oale_pkg::ADDR_IA;
        cmd.wd_sel = oale_pkg::WD_RDATA;
        state_next = S_SW_WB;
      end
      S_SW_WB: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = oale_pkg::ADDR_IB;
        cmd.wd_sel = oale_pkg::WD_TMP;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = st;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      st       <= oale_pkg::ST_OK;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      st    <= st_next;
      if (cmd.res_ld) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/ordered_array_list_engine.sv
// Top level of the ordered array list engine: controller plus datapath.
//
//   Channel  Dir  Fields (low bit first)
//   s_*      in   operation[2:0] index_a[11:3] index_b[19:12] value[51:20]
//   m_*      out  status[1:0] read_value[33:2] list_length[42:34]
//
// One request is in work at a time; the next is taken while the last result waits in m_tdata.
// Insert and delete move one entry at a time through the store, and delete by value first
// scans the entries from index 0 until it finds an equal one or reaches the list length.
// Reset empties the list at once; the store itself is not cleared.
// A stalled m_tready holds the finished result and blocks only the next result.
module ordered_array_list_engine #(
  parameter int unsigned CAPACITY      = oale_pkg::CAPACITY_DEF,
  parameter int unsigned ELEMENT_WIDTH = oale_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // operation, index_a, index_b, value; zero padded
  input  logic [oale_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // status, read_value, list_length; zero padded
  output logic [oale_pkg::M_TDATA_W-1:0] m_tdata
);

  oale_pkg::cmd_t   cmd;
  oale_pkg::flags_t flags;

  oale_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .flags    (flags),
    .cmd      (cmd)
  );

  oale_datapath #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .cmd     (cmd),
    .flags   (flags),
    .m_tdata (m_tdata)
  );

endmodule

FILE: rtl/oale_checker.sv
// Port-level checker for the ordered array list engine, bound to the top level.
`include "ordered_array_list_engine_macros.svh"

module oale_checker #(
  parameter int unsigned CAPACITY = oale_pkg::CAPACITY_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [oale_pkg::M_TDATA_W-1:0] m_tdata
);

  logic [oale_pkg::STATUS_W-1:0] status;
  logic [oale_pkg::VALUE_W-1:0]  read_value;
  logic [oale_pkg::LEN_W-1:0]    list_length;
  logic                          len_ok;
  logic                          res_stall;
  logic                          res_failed;

  assign status      = m_tdata[0 +: oale_pkg::STATUS_W];
  assign read_value  = m_tdata[oale_pkg::RV_LSB +: oale_pkg::VALUE_W];
  assign list_length = m_tdata[oale_pkg::LEN_LSB +: oale_pkg::LEN_W];
  // The length field only wraps when the capacity exceeds its range.
  assign len_ok      = (CAPACITY > 511) || (32'(list_length) <= CAPACITY);
  assign res_stall   = m_tvalid && !m_tready;
  assign res_failed  = m_tvalid && status != oale_pkg::ST_OK;

  `OALE_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !m_tvalid && s_tready, "not idle after reset")
  `OALE_ASSERT(a_one_at_a_time, clk, rst, s_tvalid && s_tready |=> !s_tready, "overlapping requests")
  `OALE_ASSERT(a_result_hold, clk, rst, res_stall |=> m_tvalid && $stable(m_tdata), "result not held")
  `OALE_ASSERT(a_failed_reads_zero, clk, rst, res_failed |-> read_value == '0, "nonzero read value")
  `OALE_ASSERT(a_length_bound, clk, rst, m_tvalid |-> len_ok, "list length above capacity")

endmodule

bind ordered_array_list_engine oale_checker #(.CAPACITY(CAPACITY)) u_oale_checker (.*);

FILE: verif/ordered_array_list_engine_tb.sv
// Self-checking testbench for the ordered array list engine: directed table, then random traffic.
module ordered_array_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIST_CAP = oale_pkg::CAPACITY_DEF;
  localparam int unsigned ITEM_GOAL = 550;
  localparam logic [oale_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [oale_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct {
    logic [oale_pkg::OP_W-1:0]    op;
    logic [oale_pkg::IDX_A_W-1:0] ia;
    logic [oale_pkg::IDX_B_W-1:0] ib;
    logic [oale_pkg::VALUE_W-1:0] val;
  } list_req_t;

  typedef struct {
    oale_pkg::status_t            status;
    logic [oale_pkg::VALUE_W-1:0] rd;
    logic [oale_pkg::LEN_W-1:0]   len;
  } list_result_t;

  // A row with known set carries its result typed in; the others rely on the predictor.
  typedef struct {
    logic [oale_pkg::OP_W-1:0]    op;
    logic [oale_pkg::IDX_A_W-1:0] ia;
    logic [oale_pkg::IDX_B_W-1:0] ib;
    logic [oale_pkg::VALUE_W-1:0] val;
    bit                           known;
    oale_pkg::status_t            st;
    logic [oale_pkg::VALUE_W-1:0] rd;
    logic [oale_pkg::LEN_W-1:0]   len;
  } table_row_t;

  table_row_t dir_table [28] = '{
    '{oale_pkg::OP_READ, 9'd0, 8'd0, 32'h0, 1, oale_pkg::ST_BAD_INDEX, 32'h0, 9'd0},
    '{oale_pkg::OP_DELETE, 9'd0, 8'd0, 32'h0, 1, oale_pkg::ST_BAD_INDEX, 32'h0, 9'd0},
    '{oale_pkg::OP_DELETE_VALUE, 9'd0, 8'd0, 32'h0, 1, oale_pkg::ST_NOT_FOUND, 32'h0, 9'd0},
    '{oale_pkg::OP_SWAP, 9'd0, 8'd1, 32'h0, 1, oale_pkg::ST_BAD_INDEX, 32'h0, 9'd0},
    '{oale_pkg::OP_INSERT, 9'd1, 8'd0, 32'h5, 1, oale_pkg::ST_BAD_INDEX, 32'h0, 9'd0},
    '{oale_pkg::OP_INSERT, 9'd0, 8'd0, 32'h7FFF_FFFF, 1, oale_pkg::ST_OK, 32'h0, 9'd1},
    '{oale_pkg::OP_INSERT, 9'd0, 8'd0, 32'h8000_0000, 1, oale_pkg::ST_OK, 32'h0, 9'd2},
    '{oale_pkg::OP_INSERT, 9'd2, 8'd0, 32'hFFFF_FFFF, 1, oale_pkg::ST_OK, 32'h0, 9'd3},
    '{oale_pkg::OP_INSERT, 9'd1, 8'd0, 32'h0, 1, oale_pkg::ST_OK, 32'h0, 9'd4},
    '{oale_pkg::OP_READ, 9'd0, 8'd0, 32'h0, 1, oale_pkg::ST_OK, 32'h8000_0000, 9'd4},
    '{oale_pkg::OP_READ, 9'd3, 8'd0, 32'h0, 1, oale_pkg::ST_OK, 32'hFFFF_FFFF, 9'd4},
    '{oale_pkg::OP_READ, 9'd256, 8'd0, 32'h0, 1, oale_pkg::ST_BAD_INDEX, 32'h0, 9'd4},
    '{oale_pkg::OP_SWAP, 9'd0, 8'd3, 32'h0, 1, oale_pkg::ST_OK, 32'h0, 9'd4},
    '{oale_pkg::OP_SWAP, 9'd2, 8'd2, 32'h0, 1, oale_pkg::ST_BAD_INDEX, 32'h0, 9'd4},
    '{oale_pkg::OP_SWAP, 9'd1, 8'd255, 32'h0, 1, oale_pkg::ST_BAD_INDEX, 32'h0, 9'd4},
    '{oale_pkg::OP_READ, 9'd0, 8'd0, 32'h0, 0, oale_pkg::ST_OK, 32'h0, 9'd0},
    '{oale_pkg::OP_DELETE_VALUE, 9'd0, 8'd0, 32'h0, 0, oale_pkg::ST_OK, 32'h0, 9'd0},
    '{oale_pkg::OP_DELETE_VALUE, 9'd0, 8'd0, 32'h3039, 1, oale_pkg::ST_NOT_FOUND, 32'h0, 9'd3},
    '{oale_pkg::OP_DELETE, 9'd0, 8'd0, 32'h0, 0, oale_pkg::ST_OK, 32'h0, 9'd0},
    '{oale_pkg::OP_INSERT, 9'd2, 8'd0, 32'h7FFF_FFFF, 0, oale_pkg::ST_OK, 32'h0, 9'd0},
    '{oale_pkg::OP_DELETE_VALUE, 9'd0, 8'd0, 32'h7FFF_FFFF, 0, oale_pkg::ST_OK, 32'h0, 9'd0},
    '{oale_pkg::OP_READ, 9'd0, 8'd0, 32'h0, 0, oale_pkg::ST_OK, 32'h0, 9'd0},
    '{oale_pkg::OP_READ, 9'd1, 8'd0, 32'h0, 0, oale_pkg::ST_OK, 32'h0, 9'd0},
    '{oale_pkg::OP_INSERT, 9'd256, 8'd0, 32'h1, 1, oale_pkg::ST_BAD_INDEX, 32'h0, 9'd2},
    '{OP_SPARE_6, 9'd0, 8'd0, 32'h0, 1, oale_pkg::ST_OK, 32'h0, 9'd2},
    '{OP_SPARE_7, 9'd256, 8'd255, 32'hFFFF_FFFF, 1, oale_pkg::ST_OK, 32'h0, 9'd2},
    '{oale_pkg::OP_CLEAR, 9'd0, 8'd0, 32'h0, 1, oale_pkg::ST_OK, 32'h0, 9'd0},
    '{oale_pkg::OP_READ, 9'd0, 8'd0, 32'h0, 1, oale_pkg::ST_BAD_INDEX, 32'h0, 9'd0}
  };

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [oale_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [oale_pkg::M_TDATA_W-1:0] m_tdata;

  // Shadow copy of the list contents and length.
  logic [oale_pkg::VALUE_W-1:0] list_words [0:LIST_CAP-1];
  int                           list_len = 0;

  list_result_t awaited_results [$];
  int           fault_count = 0;
  int           sent_total = 0;
  bit           steady = 1'b0;
  int           stall_left = 0;

  ordered_array_list_engine u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
    list_len--;
  endfunction

  function automatic list_result_t apply_list_request(list_req_t r);
    list_result_t res;
    logic [oale_pkg::VALUE_W-1:0] held;
    int hit;
    res.status = oale_pkg::ST_OK;
    res.rd = '0;
    hit = -1;
    case (r.op)
      oale_pkg::OP_READ: begin
        if (r.ia < list_len) res.rd = list_words[r.ia];
        else res.status = oale_pkg::ST_BAD_INDEX;
      end
      oale_pkg::OP_INSERT: begin
        if (r.ia > list_len) begin
          res.status = oale_pkg::ST_BAD_INDEX;
        end else if (list_len >= LIST_CAP) begin
          res.status = oale_pkg::ST_FULL;
        end else begin
          for (int i = list_len; i > r.ia; i--) list_words[i] = list_words[i - 1];
          list_words[r.ia] = r.val;
          list_len++;
        end
      end
      oale_pkg::OP_DELETE: begin
        if (r.ia < list_len) drop_entry(int'(r.ia));
        else res.status = oale_pkg::ST_BAD_INDEX;
      end
      oale_pkg::OP_DELETE_VALUE: begin
        // Only the first equal entry goes away.
        for (int i = 0; i < list_len; i++)
          if (hit < 0 && list_words[i] == r.val) hit = i;
        if (hit < 0) res.status = oale_pkg::ST_NOT_FOUND;
        else drop_entry(hit);
      end
      oale_pkg::OP_SWAP: begin
        if (r.ia < list_len && r.ib < list_len && r.ia != {1'b0, r.ib}) begin
          held = list_words[r.ia];
          list_words[r.ia] = list_words[r.ib];
          list_words[r.ib] = held;
        end else begin
          res.status = oale_pkg::ST_BAD_INDEX;
        end
      end
      oale_pkg::OP_CLEAR: list_len = 0;
      default: ;
    endcase
    res.len = list_len[oale_pkg::LEN_W-1:0];
    return res;
  endfunction

  function automatic logic [oale_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'hFFFF_FFFF;
      4: return $urandom_range(1, 4);
      default: return $urandom();
    endcase
  endfunction

  // Mostly a legal position below limit, sometimes any position from 0 to 256.
  function automatic logic [oale_pkg::IDX_A_W-1:0] pick_index(int limit);
    if (limit > 0 && $urandom_range(0, 99) < 85) return 9'($urandom_range(0, limit - 1));
    return 9'($urandom_range(0, 256));
  endfunction

  function automatic list_req_t pick_request();
    list_req_t r;
    int roll;
    roll = $urandom_range(0, 99);
    r.val = pick_value();
    r.ib = (list_len > 0 && $urandom_range(0, 99) < 85) ? 8'($urandom_range(0, list_len - 1))
                                                        : 8'($urandom_range(0, 255));
    r.ia = pick_index(list_len);
    if (roll < 32) begin
      r.op = oale_pkg::OP_INSERT;
      r.ia = pick_index(list_len + 1);
    end else if (roll < 52) begin
      r.op = oale_pkg::OP_READ;
    end else if (roll < 64) begin
      r.op = oale_pkg::OP_DELETE;
    end else if (roll < 78) begin
      r.op = oale_pkg::OP_DELETE_VALUE;
      if (list_len > 0 && $urandom_range(0, 3) != 0)
        r.val = list_words[$urandom_range(0, list_len - 1)];
    end else if (roll < 94) begin
      r.op = oale_pkg::OP_SWAP;
    end else if (roll < 96) begin
      r.op = oale_pkg::OP_CLEAR;
    end else begin
      r.op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
    end
    return r;
  endfunction

  function automatic int pick_idle();
    if (steady || $urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_request(list_req_t r, bit known, list_result_t typed);
    int idle;
    list_result_t predicted;
    if ($urandom_range(0, 39) == 0) steady = !steady;
    idle = pick_idle();
    if (idle > 0) begin
      s_tvalid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= oale_pkg::S_TDATA_W'({r.val, r.ib, r.ia, r.op});
    do @(posedge clk); while (s_tready !== 1'b1);
    predicted = apply_list_request(r);
    awaited_results.push_back(known ? typed : predicted);
    sent_total++;
  endtask

  task automatic check_result(logic [oale_pkg::M_TDATA_W-1:0] word);
    list_result_t want;
    logic [oale_pkg::STATUS_W-1:0] got_st;
    logic [oale_pkg::VALUE_W-1:0] got_rd;
    logic [oale_pkg::LEN_W-1:0] got_len;
    got_st = word[oale_pkg::STATUS_W-1:0];
    got_rd = word[oale_pkg::RV_LSB +: oale_pkg::VALUE_W];
    got_len = word[oale_pkg::LEN_LSB +: oale_pkg::LEN_W];
    if (awaited_results.size() == 0) begin
      fault_count++;
      if (fault_count <= 10)
        $display("[%0t] unexpected result: status %0d read %h length %0d",
                 $realtime, got_st, got_rd, got_len);
    end else begin
      want = awaited_results.pop_front();
      if (got_st !== want.status || got_rd !== want.rd || got_len !== want.len) begin
        fault_count++;
        if (fault_count <= 10)
          $display("[%0t] mismatch: status %0d/%0d read %h/%h length %0d/%0d (exp/got)",
                   $realtime, want.status, got_st, want.rd, got_rd, want.len, got_len);
      end
    end
  endtask

  // Result side: check each transaction, then decide the next ready level.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid === 1'b1 && m_tready) check_result(m_tdata);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    list_req_t req;
    list_result_t typed;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_table[k]) begin
      req = '{dir_table[k].op, dir_table[k].ia, dir_table[k].ib, dir_table[k].val};
      typed = '{dir_table[k].st, dir_table[k].rd, dir_table[k].len};
      send_request(req, dir_table[k].known, typed);
    end

    repeat (200) send_request(pick_request(), 1'b0, typed);

    // Let the engine drain completely before the fill phase.
    s_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);

    // Grow the list to capacity so the full-store and top-index paths get exercised.
    while (list_len < LIST_CAP) begin
      req = '{oale_pkg::OP_INSERT, 9'($urandom_range(0, list_len)),
              8'($urandom_range(0, 255)), pick_value()};
      send_request(req, 1'b0, typed);
    end
    repeat (40) send_request(pick_request(), 1'b0, typed);
    while (sent_total < ITEM_GOAL) send_request(pick_request(), 1'b0, typed);

    s_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
    repeat (16) @(posedge clk);
    if (fault_count == 0 && awaited_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
